/* sv/load_store_address_generator_defines.svh */
// ----------------------------------------------------------------------------
// load_store_address_generator_defines
// assertion macros shared by the checker of the address generator
// ----------------------------------------------------------------------------
`ifndef LOAD_STORE_ADDRESS_GENERATOR_DEFINES_SVH
`define LOAD_STORE_ADDRESS_GENERATOR_DEFINES_SVH

// clocked assertion, off while reset is held
`define LSAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// assertion on a result beat only
`define LSAG_ASSERT_BEAT(lbl, cond, msg) \
  `LSAG_ASSERT(lbl, done_o |-> (cond), msg)

`endif

/* sv/lsag_pkg.sv */
// ----------------------------------------------------------------------------
// lsag_pkg
// types and constants shared by the load/store address generator stages
// ----------------------------------------------------------------------------
`default_nettype none

package lsag_pkg;

  localparam int unsigned XLEN   = 64;
  localparam int unsigned IWIDTH = 32;
  localparam int unsigned RWIDTH = 5;

  // control that travels unchanged down the pipe
  typedef struct packed {
    logic              is_load;
    logic              wide;
    logic              wb;
    logic              post;
    logic [RWIDTH-1:0] target_reg;
    logic [RWIDTH-1:0] base_reg;
  } ctrl_t;

  // decode stage beat: adder operands
  typedef struct packed {
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;
    logic [XLEN-1:0] store_data;
    ctrl_t           ctrl;
  } dec_t;

  // add stage beat: sum and untouched base
  typedef struct packed {
    logic [XLEN-1:0] sum;
    logic [XLEN-1:0] base;
    logic [XLEN-1:0] store_data;
    ctrl_t           ctrl;
  } sum_t;

endpackage

`default_nettype wire

/* sv/lsag_decode.sv */
// ----------------------------------------------------------------------------
// lsag_decode
// first stage: decodes the instruction word and picks the adder operands
// ----------------------------------------------------------------------------
`default_nettype none

module lsag_decode import lsag_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [IWIDTH-1:0] instruction_i,
  input  logic [XLEN-1:0]   base_value_i,
  input  logic [XLEN-1:0]   index_value_i,
  input  logic [XLEN-1:0]   transfer_value_i,
  input  logic [XLEN-1:0]   pc_value_i,
  output logic              valid_o,
  output dec_t              dec_o
);

  logic   valid_q;
  dec_t   dec_d, dec_q;
  logic   transfer, wide, unsig, reg_off;

  assign transfer = instruction_i[31];
  assign wide     = instruction_i[30];
  assign unsig    = instruction_i[24];
  assign reg_off  = instruction_i[21];

  // operand selection per address mode
  always_comb begin
    dec_d                 = '0;
    dec_d.ctrl.wide       = wide;
    dec_d.ctrl.target_reg = instruction_i[4:0];
    if (transfer) begin
      dec_d.op_a          = base_value_i;
      dec_d.ctrl.base_reg = instruction_i[9:5];
      dec_d.ctrl.is_load  = instruction_i[22];
      if (unsig) begin
        // scaled unsigned imm12
        dec_d.op_b = wide ? {49'b0, instruction_i[21:10], 3'b000}
                          : {50'b0, instruction_i[21:10], 2'b00};
      end else if (reg_off) begin
        dec_d.op_b = index_value_i;
      end else begin
        // signed 9-bit offset with base writeback
        dec_d.op_b      = {{55{instruction_i[20]}}, instruction_i[20:12]};
        dec_d.ctrl.wb   = 1'b1;
        dec_d.ctrl.post = !instruction_i[11];
      end
      if (!instruction_i[22]) begin
        dec_d.store_data = wide ? transfer_value_i : {32'b0, transfer_value_i[31:0]};
      end
    end else begin
      // pc-relative literal load, word offset
      dec_d.op_a         = pc_value_i;
      dec_d.op_b         = {{43{instruction_i[23]}}, instruction_i[23:5], 2'b00};
      dec_d.ctrl.is_load = 1'b1;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

/* sv/lsag_add.sv */
// ----------------------------------------------------------------------------
// lsag_add
// second stage: the single 64-bit address adder
// ----------------------------------------------------------------------------
`default_nettype none

module lsag_add import lsag_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  dec_t dec_i,
  output logic valid_o,
  output sum_t sum_o
);

  logic valid_q;
  sum_t sum_d, sum_q;

  // sum wraps modulo 2^64
  always_comb begin
    sum_d.sum        = dec_i.op_a + dec_i.op_b;
    sum_d.base       = dec_i.op_a;
    sum_d.store_data = dec_i.store_data;
    sum_d.ctrl       = dec_i.ctrl;
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

/* sv/load_store_address_generator.sv */
// ----------------------------------------------------------------------------
// load_store_address_generator
// memory request former for single-data-transfer and load-literal words
// ----------------------------------------------------------------------------
// One instruction is taken on every clock edge with start_i high; busy_o
// stays low, so the block never refuses a beat. Each request appears on the
// result ports for one cycle, marked by done_o, after passing decode and
// operand select, the one 64-bit address adder, then the pre/post-index
// select into the output register. The receiver cannot stall and must take
// every done_o beat as it comes.
`default_nettype none

module load_store_address_generator import lsag_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [IWIDTH-1:0] instruction_i,
  input  logic [XLEN-1:0]   base_value_i,
  input  logic [XLEN-1:0]   index_value_i,
  input  logic [XLEN-1:0]   transfer_value_i,
  input  logic [XLEN-1:0]   pc_value_i,
  output logic              done_o,
  output logic [XLEN-1:0]   mem_address_o,
  output logic              is_load_o,
  output logic              wide_access_o,
  output logic [XLEN-1:0]   store_data_o,
  output logic [RWIDTH-1:0] target_reg_o,
  output logic [RWIDTH-1:0] base_reg_o,
  output logic              base_writeback_o,
  output logic [XLEN-1:0]   writeback_value_o
);

  logic              accept;
  logic              dec_valid, sum_valid;
  dec_t              dec;
  sum_t              sum;
  logic              done_q;
  logic [XLEN-1:0]   addr_d, addr_q, wbval_d, wbval_q, sdata_q;
  ctrl_t             ctrl_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  lsag_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (accept),
    .instruction_i    (instruction_i),
    .base_value_i     (base_value_i),
    .index_value_i    (index_value_i),
    .transfer_value_i (transfer_value_i),
    .pc_value_i       (pc_value_i),
    .valid_o          (dec_valid),
    .dec_o            (dec)
  );

  lsag_add u_add (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .dec_i   (dec),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  // post-index uses the old base, writeback value only when updating
  always_comb begin
    addr_d  = (sum.ctrl.wb && sum.ctrl.post) ? sum.base : sum.sum;
    wbval_d = sum.ctrl.wb ? sum.sum : '0;
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sum_valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (sum_valid) begin
      addr_q  <= addr_d;
      wbval_q <= wbval_d;
      sdata_q <= sum.store_data;
      ctrl_q  <= sum.ctrl;
    end
  end

  assign done_o            = done_q;
  assign mem_address_o     = addr_q;
  assign is_load_o         = ctrl_q.is_load;
  assign wide_access_o     = ctrl_q.wide;
  assign store_data_o      = sdata_q;
  assign target_reg_o      = ctrl_q.target_reg;
  assign base_reg_o        = ctrl_q.base_reg;
  assign base_writeback_o  = ctrl_q.wb;
  assign writeback_value_o = wbval_q;

endmodule

`default_nettype wire

/* sv/lsag_checker.sv */
// ----------------------------------------------------------------------------
// lsag_checker
// port-level checks of the address generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "load_store_address_generator_defines.svh"

module lsag_checker import lsag_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic            done_o,
  input logic            is_load_o,
  input logic            wide_access_o,
  input logic [XLEN-1:0] store_data_o,
  input logic            base_writeback_o,
  input logic [XLEN-1:0] writeback_value_o
);

  // every start beat yields a result on done_o, and no result comes without one
  `LSAG_ASSERT(a_start_to_done, (start_i && !busy_o) |-> ##3 done_o, "start beat without result")
  `LSAG_ASSERT(a_done_from_start, done_o |-> $past(start_i && !busy_o, 3), "result without start beat")

  // field rules of a result beat
  `LSAG_ASSERT_BEAT(a_load_no_data, !is_load_o || (store_data_o == '0), "load carries store data")
  `LSAG_ASSERT_BEAT(a_narrow_data, wide_access_o || (store_data_o[63:32] == '0), "narrow store upper bits set")
  `LSAG_ASSERT_BEAT(a_no_wb_value, base_writeback_o || (writeback_value_o == '0), "writeback value without writeback")

endmodule

bind load_store_address_generator lsag_checker u_lsag_checker (.*);

`default_nettype wire

/* dv/load_store_address_generator_test.sv */
// ----------------------------------------------------------------------------
// load_store_address_generator_test
// self-checking bench for the load/store address generator: a directed table
// of corners, then random transfer and literal words in phases of varied
// sender idle rate, each result checked against a pinned value or a decoder
// ----------------------------------------------------------------------------

module load_store_address_generator_test;
  import lsag_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BEATS = 185;

  // instruction word bit positions
  localparam int unsigned BIT_TRANSFER = 31;
  localparam int unsigned BIT_WIDE     = 30;
  localparam int unsigned BIT_UNSIGNED = 24;
  localparam int unsigned BIT_LOAD     = 22;
  localparam int unsigned BIT_REG_OFF  = 21;
  localparam int unsigned BIT_PRE      = 11;

  // shape of a generated word
  typedef enum logic [2:0] {
    FORM_LITERAL,
    FORM_UNSIGNED,
    FORM_REGISTER,
    FORM_POST,
    FORM_PRE,
    FORM_RAW
  } form_e;

  typedef struct packed {
    logic [XLEN-1:0]   mem_address;
    logic              is_load;
    logic              wide_access;
    logic [XLEN-1:0]   store_data;
    logic [RWIDTH-1:0] target_reg;
    logic [RWIDTH-1:0] base_reg;
    logic              base_writeback;
    logic [XLEN-1:0]   writeback_value;
  } request_t;

  typedef struct {
    logic [IWIDTH-1:0] word;
    logic [XLEN-1:0]   base;
    logic [XLEN-1:0]   index;
    logic [XLEN-1:0]   xfer;
    logic [XLEN-1:0]   pc;
    bit                pinned;
    request_t          want;
  } beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [IWIDTH-1:0] instruction_i;
  logic [XLEN-1:0]   base_value_i;
  logic [XLEN-1:0]   index_value_i;
  logic [XLEN-1:0]   transfer_value_i;
  logic [XLEN-1:0]   pc_value_i;
  logic              done_o;
  logic [XLEN-1:0]   mem_address_o;
  logic              is_load_o;
  logic              wide_access_o;
  logic [XLEN-1:0]   store_data_o;
  logic [RWIDTH-1:0] target_reg_o;
  logic [RWIDTH-1:0] base_reg_o;
  logic              base_writeback_o;
  logic [XLEN-1:0]   writeback_value_o;

  // typed-in expectation travelling with the driven beat
  bit                beat_pinned;
  request_t          beat_want;

  request_t          pending_requests[$];
  int unsigned       mismatch_count;
  int unsigned       cycle_count;

  load_store_address_generator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .instruction_i    (instruction_i),
    .base_value_i     (base_value_i),
    .index_value_i    (index_value_i),
    .transfer_value_i (transfer_value_i),
    .pc_value_i       (pc_value_i),
    .done_o           (done_o),
    .mem_address_o    (mem_address_o),
    .is_load_o        (is_load_o),
    .wide_access_o    (wide_access_o),
    .store_data_o     (store_data_o),
    .target_reg_o     (target_reg_o),
    .base_reg_o       (base_reg_o),
    .base_writeback_o (base_writeback_o),
    .writeback_value_o(writeback_value_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // memory request decode of one word
  function automatic request_t form_request(logic [IWIDTH-1:0] word, logic [XLEN-1:0] base,
                                            logic [XLEN-1:0] index, logic [XLEN-1:0] xfer,
                                            logic [XLEN-1:0] pc);
    request_t        req;
    logic [XLEN-1:0] moved;
    req = '0;
    req.wide_access = word[BIT_WIDE];
    req.target_reg  = word[4:0];
    req.is_load     = 1'b1;
    if (word[BIT_TRANSFER]) begin
      req.base_reg = word[9:5];
      req.is_load  = word[BIT_LOAD];
      if (word[BIT_UNSIGNED]) begin
        // scaled imm12 wins over the register-offset bit
        req.mem_address = base + ({52'd0, word[21:10]} << (word[BIT_WIDE] ? 3 : 2));
      end else if (word[BIT_REG_OFF]) begin
        req.mem_address = base + index;
      end else begin
        moved = base + {{55{word[20]}}, word[20:12]};
        req.mem_address     = word[BIT_PRE] ? moved : base;
        req.base_writeback  = 1'b1;
        req.writeback_value = moved;
      end
      if (!req.is_load) begin
        req.store_data = word[BIT_WIDE] ? xfer : {32'd0, xfer[31:0]};
      end
    end else begin
      // pc-relative word offset
      req.mem_address = pc + ({{45{word[23]}}, word[23:5]} << 2);
    end
    return req;
  endfunction

  function automatic logic [IWIDTH-1:0] enc_transfer(bit wide, bit load, bit unsig,
                                                     logic [11:0] off12, logic [4:0] rn,
                                                     logic [4:0] rt);
    logic [IWIDTH-1:0] word;
    word = '0;
    word[BIT_TRANSFER] = 1'b1;
    word[BIT_WIDE]     = wide;
    word[BIT_UNSIGNED] = unsig;
    word[BIT_LOAD]     = load;
    word[21:10]        = off12;
    word[9:5]          = rn;
    word[4:0]          = rt;
    return word;
  endfunction

  function automatic logic [IWIDTH-1:0] enc_literal(bit wide, logic [18:0] imm19,
                                                    logic [4:0] rt);
    logic [IWIDTH-1:0] word;
    word = '0;
    word[BIT_WIDE] = wide;
    word[23:5]     = imm19;
    word[4:0]      = rt;
    return word;
  endfunction

  function automatic request_t make_req(logic [XLEN-1:0] addr, bit load, bit wide,
                                        logic [XLEN-1:0] sdata, logic [4:0] rt,
                                        logic [4:0] rn, bit wb, logic [XLEN-1:0] wbv);
    request_t req;
    req.mem_address     = addr;
    req.is_load         = load;
    req.wide_access     = wide;
    req.store_data      = sdata;
    req.target_reg      = rt;
    req.base_reg        = rn;
    req.base_writeback  = wb;
    req.writeback_value = wbv;
    return req;
  endfunction

  function automatic beat_t make_beat(logic [IWIDTH-1:0] word, logic [XLEN-1:0] base,
                                      logic [XLEN-1:0] index, logic [XLEN-1:0] xfer,
                                      logic [XLEN-1:0] pc, bit pinned, request_t want);
    beat_t b;
    b.word   = word;
    b.base   = base;
    b.index  = index;
    b.xfer   = xfer;
    b.pc     = pc;
    b.pinned = pinned;
    b.want   = want;
    return b;
  endfunction

  // 64-bit operand, biased toward the edges
  function automatic logic [XLEN-1:0] rand_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return XLEN'($urandom_range(4095));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [8:0] rand_simm9();
    case ($urandom_range(5))
      0: return 9'h100;
      1: return 9'h0ff;
      2: return 9'h1ff;
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic beat_t rand_beat();
    form_e             form;
    logic [IWIDTH-1:0] word;
    logic [11:0]       off12;
    bit                wide;
    bit                load;
    logic [4:0]        rn;
    logic [4:0]        rt;
    wide = 1'($urandom);
    load = 1'($urandom);
    rn   = 5'($urandom);
    rt   = 5'($urandom);
    if ($urandom_range(99) < 15) form = FORM_RAW;
    else form = form_e'($urandom_range(FORM_PRE));
    case (form)
      FORM_LITERAL: begin
        word = enc_literal(wide, 19'($urandom), rt);
        if ($urandom_range(1)) word[29:24] = 6'($urandom);
      end
      FORM_UNSIGNED: begin
        off12 = ($urandom_range(3) == 0) ? 12'hfff : 12'($urandom);
        word  = enc_transfer(wide, load, 1'b1, off12, rn, rt);
      end
      FORM_REGISTER: begin
        off12 = {1'b1, 11'($urandom)};
        word  = enc_transfer(wide, load, 1'b0, off12, rn, rt);
      end
      FORM_POST, FORM_PRE: begin
        off12 = {1'b0, rand_simm9(), form == FORM_PRE, 1'($urandom)};
        word  = enc_transfer(wide, load, 1'b0, off12, rn, rt);
      end
      default: word = $urandom;
    endcase
    // bits the decoder ignores on transfer words
    if (form != FORM_LITERAL && form != FORM_RAW && $urandom_range(1)) begin
      word[29:25] = 5'($urandom);
      word[23]    = 1'($urandom);
    end
    return make_beat(word, rand_operand(), rand_operand(), rand_operand(), rand_operand(),
                     1'b0, '0);
  endfunction

  // drive one beat after a random gap and hold it until accepted
  task automatic issue_beat(input beat_t b, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i          <= 1'b1;
    instruction_i    <= b.word;
    base_value_i     <= b.base;
    index_value_i    <= b.index;
    transfer_value_i <= b.xfer;
    pc_value_i       <= b.pc;
    beat_pinned      <= b.pinned;
    beat_want        <= b.want;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [XLEN-1:0] want,
                             input logic [XLEN-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endtask

  // result check and capture of accepted beats
  always @(posedge clk_i) begin
    request_t want;
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) begin
        if (pending_requests.size() == 0) begin
          $error("result beat with no request outstanding, address %h", mem_address_o);
          mismatch_count++;
        end else begin
          want = pending_requests.pop_front();
          check_field("mem_address", want.mem_address, mem_address_o);
          check_field("is_load", want.is_load, is_load_o);
          check_field("wide_access", want.wide_access, wide_access_o);
          check_field("store_data", want.store_data, store_data_o);
          check_field("target_reg", want.target_reg, target_reg_o);
          check_field("base_reg", want.base_reg, base_reg_o);
          check_field("base_writeback", want.base_writeback, base_writeback_o);
          check_field("writeback_value", want.writeback_value, writeback_value_o);
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        pending_requests.push_back(beat_pinned ? beat_want :
          form_request(instruction_i, base_value_i, index_value_i, transfer_value_i,
                       pc_value_i));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[load_store_address_generator] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    beat_t       corners[$];
    int unsigned idle_pct[4];
    start_i          = 1'b0;
    instruction_i    = '0;
    base_value_i     = '0;
    index_value_i    = '0;
    transfer_value_i = '0;
    pc_value_i       = '0;
    beat_pinned      = 1'b0;
    beat_want        = '0;
    mismatch_count   = 0;
    cycle_count      = 0;
    rst_ni           = 1'b0;
    idle_pct         = '{0, 65, 0, 13};

    // literal forms: zero word, offset extremes, junk in bits 29..24
    corners.push_back(make_beat('0, '1, '1, '1, 64'h1234, 1'b1,
                                make_req(64'h1234, 1, 0, '0, 0, 0, 0, '0)));
    corners.push_back(make_beat(enc_literal(1, 19'h3ffff, 5'd7), '0, '0, '1, '0, 1'b1,
                                make_req(64'hf_fffc, 1, 1, '0, 7, 0, 0, '0)));
    corners.push_back(make_beat(enc_literal(0, 19'h40000, 5'd31), '1, '0, '0, '0, 1'b1,
                                make_req(64'hffff_ffff_fff0_0000, 1, 0, '0, 31, 0, 0, '0)));
    corners.push_back(make_beat(enc_literal(1, 19'h1, 5'd3) | 32'h3f00_0000, '1, '1, '1,
                                64'hffff_ffff_ffff_fffc, 1'b0, '0));
    // scaled unsigned offset, both widths, load and store
    corners.push_back(make_beat(enc_transfer(1, 1, 1, 12'hfff, 5'd31, 5'd31), '0, '1, '1,
                                '1, 1'b1, make_req(64'h7ff8, 1, 1, '0, 31, 31, 0, '0)));
    corners.push_back(make_beat(enc_transfer(0, 0, 1, 12'hfff, 5'd1, 5'd2), '0, '0, '1,
                                '0, 1'b1,
                                make_req(64'h3ffc, 0, 0, 64'hffff_ffff, 2, 1, 0, '0)));
    corners.push_back(make_beat(enc_transfer(1, 0, 1, 12'h000, 5'd0, 5'd0), '1, '0, '1,
                                '0, 1'b1, make_req('1, 0, 1, '1, 0, 0, 0, '0)));
    // unsigned bit takes precedence over the register-offset bit
    corners.push_back(make_beat(enc_transfer(0, 1, 1, 12'h800, 5'd4, 5'd5), 64'h100,
                                64'h5555, '1, '0, 1'b0, '0));
    // register offset, wrapping sum
    corners.push_back(make_beat(enc_transfer(1, 1, 0, 12'h800, 5'd9, 5'd10), '1, 64'd1,
                                '1, '0, 1'b1, make_req('0, 1, 1, '0, 10, 9, 0, '0)));
    corners.push_back(make_beat(enc_transfer(0, 0, 0, 12'hfff, 5'd30, 5'd29),
                                64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                                64'hdead_beef_cafe_f00d, '0, 1'b0, '0));
    // post- and pre-index, offset extremes
    corners.push_back(make_beat(enc_transfer(1, 1, 0, {1'b0, 9'h100, 2'b00}, 5'd6, 5'd8),
                                64'h1000, '0, '1, '0, 1'b1,
                                make_req(64'h1000, 1, 1, '0, 8, 6, 1, 64'h0f00)));
    corners.push_back(make_beat(enc_transfer(0, 0, 0, {1'b0, 9'h0ff, 2'b10}, 5'd11, 5'd12),
                                64'h1000, '0, 64'hdead_beef_cafe_f00d, '0, 1'b1,
                                make_req(64'h10ff, 0, 0, 64'hcafe_f00d, 12, 11, 1,
                                         64'h10ff)));
    corners.push_back(make_beat(enc_transfer(0, 1, 0, {1'b0, 9'h1ff, 2'b11}, 5'd13, 5'd14),
                                '0, '0, '1, '0, 1'b1,
                                make_req('1, 1, 0, '0, 14, 13, 1, '1)));
    corners.push_back(make_beat(enc_transfer(1, 0, 0, {1'b0, 9'h000, 2'b01}, 5'd15, 5'd16),
                                64'h8000_0000_0000_0000, '0, 64'h8000_0000_0000_0001, '0,
                                1'b0, '0));
    // every ignored bit set
    corners.push_back(make_beat('1, 64'h7fff_ffff_ffff_ffff, '1, '1, '1, 1'b0, '0));
    corners.push_back(make_beat(32'hbe80_0421, 64'h55aa_55aa_55aa_55aa, '0,
                                64'haa55_aa55_aa55_aa55, '0, 1'b0, '0));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 0) begin
        foreach (corners[i]) issue_beat(corners[i], idle_pct[phase]);
      end
      for (int n = 0; n < RANDOM_BEATS; n++) issue_beat(rand_beat(), idle_pct[phase]);
      // hold off until the pipe has emptied
      start_i <= 1'b0;
      while (pending_requests.size() != 0) @(negedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[load_store_address_generator] OK");
    end else begin
      $display("[load_store_address_generator] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/lsag_pkg.sv
sv/lsag_decode.sv
sv/lsag_add.sv
sv/load_store_address_generator.sv
sv/lsag_checker.sv
dv/load_store_address_generator_test.sv
